// ===== hdl/psc_pkg.sv =====
// Shared types, codes and helpers of the pulse unit state controller.
package psc_pkg;

    localparam int OP_W    = 4;
    localparam int VOLT_W  = 16;
    localparam int CFG_W   = 16;
    localparam int CODE_W  = 3;
    localparam int ERR_W   = 2;
    localparam int IDX_W   = 3;
    localparam int PAUSE_W = CFG_W + 1;

    localparam logic [OP_W-1:0] OP_TICK        = 4'd0;
    localparam logic [OP_W-1:0] OP_ENABLE      = 4'd1;
    localparam logic [OP_W-1:0] OP_DISABLE     = 4'd2;
    localparam logic [OP_W-1:0] OP_CONFIGURE   = 4'd3;
    localparam logic [OP_W-1:0] OP_SOFT_START  = 4'd4;
    localparam logic [OP_W-1:0] OP_STOP        = 4'd5;
    localparam logic [OP_W-1:0] OP_CLEAR_FAULT = 4'd6;
    localparam logic [OP_W-1:0] OP_CLEAR_WARN  = 4'd7;
    localparam logic [OP_W-1:0] OP_EXT_START   = 4'd8;
    localparam logic [OP_W-1:0] OP_PULSE_DONE  = 4'd9;

    localparam logic [ERR_W-1:0] ERR_OK       = 2'd0;
    localparam logic [ERR_W-1:0] ERR_BLOCKED  = 2'd1;
    localparam logic [ERR_W-1:0] ERR_NOTREADY = 2'd2;

    localparam logic [IDX_W-1:0] REG_FULL_CHARGE = 3'd0;
    localparam logic [IDX_W-1:0] REG_RECHARGE    = 3'd1;
    localparam logic [IDX_W-1:0] REG_CFG_HOLD    = 3'd2;
    localparam logic [IDX_W-1:0] REG_PAUSE       = 3'd3;
    localparam logic [IDX_W-1:0] REG_THRESHOLD   = 3'd4;

    localparam logic [CODE_W-1:0] DEV_NONE     = 3'd0;
    localparam logic [CODE_W-1:0] DEV_INPROC   = 3'd1;
    localparam logic [CODE_W-1:0] DEV_READY    = 3'd2;
    localparam logic [CODE_W-1:0] DEV_CFGREADY = 3'd3;
    localparam logic [CODE_W-1:0] DEV_FAULT    = 3'd4;

    localparam logic [CODE_W-1:0] SUBC_NONE      = 3'd0;
    localparam logic [CODE_W-1:0] SUBC_POWERPREP = 3'd1;
    localparam logic [CODE_W-1:0] SUBC_PULSEPREP = 3'd2;
    localparam logic [CODE_W-1:0] SUBC_PULSE     = 3'd3;
    localparam logic [CODE_W-1:0] SUBC_WAIT      = 3'd4;

    typedef enum logic [4:0] {
        ST_NONE     = 5'b00001,
        ST_INPROC   = 5'b00010,
        ST_READY    = 5'b00100,
        ST_CFGREADY = 5'b01000,
        ST_FAULT    = 5'b10000
    } t_main_state;

    typedef enum logic [4:0] {
        SUB_NONE      = 5'b00001,
        SUB_POWERPREP = 5'b00010,
        SUB_PULSEPREP = 5'b00100,
        SUB_PULSE     = 5'b01000,
        SUB_WAIT      = 5'b10000
    } t_sub_state;

    typedef struct packed {
        logic [CFG_W-1:0] full_charge_timeout;
        logic [CFG_W-1:0] recharge_timeout;
        logic [CFG_W-1:0] config_hold_timeout;
        logic [CFG_W-1:0] after_pulse_pause;
        logic [CFG_W-1:0] battery_threshold;
    } t_cfg;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [VOLT_W-1:0] battery_voltage;
        logic              pulse_done;
    } t_req;

    typedef struct packed {
        logic [CODE_W-1:0] device_state;
        logic [CODE_W-1:0] sub_state;
        logic [ERR_W-1:0]  error_code;
        logic              fault_reason;
        logic              op_result;
        logic              power_enable;
        logic              board_locked;
        logic              pulse_timer_run;
    } t_res;

    function automatic logic [CODE_W-1:0] main_code(input t_main_state st);
        logic [CODE_W-1:0] code;
        case (st)
            ST_NONE:     code = DEV_NONE;
            ST_INPROC:   code = DEV_INPROC;
            ST_READY:    code = DEV_READY;
            ST_CFGREADY: code = DEV_CFGREADY;
            ST_FAULT:    code = DEV_FAULT;
            default:     code = DEV_NONE;
        endcase
        return code;
    endfunction

    function automatic logic [CODE_W-1:0] sub_code(input t_sub_state st);
        logic [CODE_W-1:0] code;
        case (st)
            SUB_NONE:      code = SUBC_NONE;
            SUB_POWERPREP: code = SUBC_POWERPREP;
            SUB_PULSEPREP: code = SUBC_PULSEPREP;
            SUB_PULSE:     code = SUBC_PULSE;
            SUB_WAIT:      code = SUBC_WAIT;
            default:       code = SUBC_NONE;
        endcase
        return code;
    endfunction

endpackage

// ===== hdl/psc_cfg_regs.sv =====
// Configuration register file of the pulse unit state controller.
module psc_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_wr_en,
    input  logic [psc_pkg::IDX_W-1:0]    i_index,
    input  logic [psc_pkg::CFG_W-1:0]    i_data,
    output psc_pkg::t_cfg                o_cfg
);
    import psc_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_wr_en) begin
            case (i_index)
                REG_FULL_CHARGE: r_cfg.full_charge_timeout <= i_data;
                REG_RECHARGE:    r_cfg.recharge_timeout    <= i_data;
                REG_CFG_HOLD:    r_cfg.config_hold_timeout <= i_data;
                REG_PAUSE:       r_cfg.after_pulse_pause   <= i_data;
                REG_THRESHOLD:   r_cfg.battery_threshold   <= i_data;
                default: begin
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hdl/psc_core.sv =====
// Device state machine with deadline countdowns and drive flags.
module psc_core (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  psc_pkg::t_cfg i_cfg,
    input  logic          i_req_valid,
    input  psc_pkg::t_req i_req,
    output psc_pkg::t_res o_res
);
    import psc_pkg::*;

    t_main_state          r_main, n_main;
    t_sub_state           r_sub, n_sub;
    logic [CFG_W-1:0]     r_chg_left, n_chg_left;
    logic [CFG_W-1:0]     r_cfg_left, n_cfg_left;
    logic [PAUSE_W-1:0]   r_pause_left, n_pause_left;
    logic                 r_fault, n_fault;
    logic                 r_result, n_result;
    logic                 r_power, n_power;
    logic                 r_lock, n_lock;
    logic                 r_timer, n_timer;
    logic [ERR_W-1:0]     n_err;
    logic                 w_charged;
    logic [PAUSE_W-1:0]   w_pause_set;

    assign w_charged   = i_req.battery_voltage >= i_cfg.battery_threshold;
    assign w_pause_set = {1'b0, i_cfg.after_pulse_pause} + PAUSE_W'(1);

    always_comb begin
        logic do_check;
        n_main       = r_main;
        n_sub        = r_sub;
        n_chg_left   = r_chg_left;
        n_cfg_left   = r_cfg_left;
        n_pause_left = r_pause_left;
        n_fault      = r_fault;
        n_result     = r_result;
        n_power      = r_power;
        n_lock       = r_lock;
        n_timer      = r_timer;
        n_err        = ERR_OK;
        do_check     = 1'b0;

        case (i_req.op)
            OP_TICK: begin
                // advance time: count every deadline down, saturating
                n_chg_left   = (r_chg_left == '0) ? '0 : r_chg_left - CFG_W'(1);
                n_cfg_left   = (r_cfg_left == '0) ? '0 : r_cfg_left - CFG_W'(1);
                n_pause_left = (r_pause_left == '0) ? '0 : r_pause_left - PAUSE_W'(1);
                if (r_sub == SUB_PULSE && i_req.pulse_done) begin
                    n_timer      = 1'b0;
                    n_lock       = 1'b1;
                    n_pause_left = w_pause_set;
                    n_chg_left   = i_cfg.recharge_timeout;
                    n_main       = ST_INPROC;
                    n_sub        = SUB_WAIT;
                    n_result     = 1'b1;
                end
                case (n_sub)
                    SUB_POWERPREP: do_check = 1'b1;
                    SUB_PULSEPREP: begin
                        n_main = ST_CFGREADY;
                        n_sub  = SUB_NONE;
                    end
                    SUB_WAIT: do_check = (n_pause_left == '0);
                    default: begin
                        if (n_main == ST_CFGREADY && n_cfg_left == '0) begin
                            n_main = ST_READY;
                            n_sub  = SUB_NONE;
                        end
                    end
                endcase
                if (do_check) begin
                    if (w_charged) begin
                        n_main = ST_READY;
                        n_sub  = SUB_NONE;
                    end else if (n_chg_left == '0) begin
                        n_result = 1'b0;
                        n_lock   = 1'b1;
                        n_power  = 1'b0;
                        n_main   = ST_FAULT;
                        n_sub    = SUB_NONE;
                        n_fault  = 1'b1;
                    end
                end
            end
            OP_ENABLE: begin
                if (r_main == ST_NONE) begin
                    n_chg_left = i_cfg.full_charge_timeout;
                    n_main     = ST_INPROC;
                    n_sub      = SUB_POWERPREP;
                    n_power    = 1'b1;
                end else if (r_main != ST_READY) begin
                    n_err = ERR_BLOCKED;
                end
            end
            OP_DISABLE: begin
                if (r_main == ST_READY || (r_main == ST_INPROC && r_sub == SUB_POWERPREP)) begin
                    n_fault  = 1'b0;
                    n_result = 1'b0;
                    n_lock   = 1'b1;
                    n_power  = 1'b0;
                    n_main   = ST_NONE;
                    n_sub    = SUB_NONE;
                end else if (r_main != ST_NONE) begin
                    n_err = ERR_BLOCKED;
                end
            end
            OP_CONFIGURE: begin
                if (r_main == ST_READY) begin
                    n_fault    = 1'b0;
                    n_result   = 1'b0;
                    n_cfg_left = i_cfg.config_hold_timeout;
                    n_main     = ST_INPROC;
                    n_sub      = SUB_PULSEPREP;
                end else begin
                    n_err = (r_main == ST_INPROC) ? ERR_BLOCKED : ERR_NOTREADY;
                end
            end
            OP_SOFT_START: begin
                if (r_main == ST_CFGREADY) begin
                    n_main  = ST_INPROC;
                    n_sub   = SUB_PULSE;
                    n_lock  = 1'b0;
                    n_timer = 1'b1;
                end else begin
                    n_err = (r_main == ST_INPROC) ? ERR_BLOCKED : ERR_NOTREADY;
                end
            end
            OP_STOP: begin
                if (r_main == ST_INPROC) begin
                    n_timer      = 1'b0;
                    n_lock       = 1'b1;
                    n_pause_left = w_pause_set;
                    n_chg_left   = i_cfg.recharge_timeout;
                    n_main       = ST_READY;
                    n_sub        = SUB_NONE;
                end
            end
            OP_CLEAR_FAULT: begin
                if (r_main == ST_FAULT) begin
                    n_main  = ST_NONE;
                    n_sub   = SUB_NONE;
                    n_fault = 1'b0;
                end
            end
            OP_CLEAR_WARN: begin
            end
            OP_EXT_START: begin
                if (r_main == ST_CFGREADY) begin
                    n_main  = ST_INPROC;
                    n_sub   = SUB_PULSE;
                    n_lock  = 1'b0;
                    n_timer = 1'b1;
                end
            end
            OP_PULSE_DONE: begin
                if (r_sub == SUB_PULSE) begin
                    n_timer      = 1'b0;
                    n_lock       = 1'b1;
                    n_pause_left = w_pause_set;
                    n_chg_left   = i_cfg.recharge_timeout;
                    n_main       = ST_INPROC;
                    n_sub        = SUB_WAIT;
                    n_result     = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main       <= ST_NONE;
            r_sub        <= SUB_NONE;
            r_chg_left   <= '0;
            r_cfg_left   <= '0;
            r_pause_left <= PAUSE_W'(1);
            r_fault      <= 1'b0;
            r_result     <= 1'b0;
            r_power      <= 1'b0;
            r_lock       <= 1'b1;
            r_timer      <= 1'b0;
        end else if (i_req_valid) begin
            r_main       <= n_main;
            r_sub        <= n_sub;
            r_chg_left   <= n_chg_left;
            r_cfg_left   <= n_cfg_left;
            r_pause_left <= n_pause_left;
            r_fault      <= n_fault;
            r_result     <= n_result;
            r_power      <= n_power;
            r_lock       <= n_lock;
            r_timer      <= n_timer;
        end
    end

    assign o_res.device_state    = main_code(n_main);
    assign o_res.sub_state       = sub_code(n_sub);
    assign o_res.error_code      = n_err;
    assign o_res.fault_reason    = n_fault;
    assign o_res.op_result       = n_result;
    assign o_res.power_enable    = n_power;
    assign o_res.board_locked    = n_lock;
    assign o_res.pulse_timer_run = n_timer;

`ifndef SYNTH
    a_timer_in_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_timer == (r_sub == SUB_PULSE))
        else $error("pulse timer out of step with pulse substate");

    a_lock_vs_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lock == !r_timer)
        else $error("board unlocked outside a running pulse");

    a_power_vs_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_power == !(r_main == ST_NONE || r_main == ST_FAULT))
        else $error("power drive disagrees with device state");

    a_fault_vs_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fault == (r_main == ST_FAULT))
        else $error("fault reason disagrees with fault state");

    a_sub_only_inproc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sub != SUB_NONE) == (r_main == ST_INPROC))
        else $error("substate set outside in-process state");
`endif

endmodule

// ===== hdl/pulse_unit_state_controller.sv =====
// Top level of the pulse unit state controller: request and result registers.
//
//  channel | handshake                 | payload
//  --------+---------------------------+----------------------------------------------
//  in      | i_in_valid / o_in_stall   | i_op, i_battery_voltage, i_pulse_done
//  out     | o_out_valid / i_out_stall | o_device_state, o_sub_state, o_error_code,
//          |                           | o_fault_reason, o_op_result, o_power_enable,
//          |                           | o_board_locked, o_pulse_timer_run
//  cfg     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  One request per cycle unless an output stall backs up; each result passes the request
//  register, then the result register after the state update.
//  Deadlines are kept as tick countdowns updated in the same cycle as the state.
//  Synchronous active-low reset clears state; the board lock drive resets locked.
//  An output stall holds the result register and backs up into the request stage.
module pulse_unit_state_controller (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [psc_pkg::OP_W-1:0]      i_op,
    input  logic [psc_pkg::VOLT_W-1:0]    i_battery_voltage,
    input  logic                          i_pulse_done,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [psc_pkg::CODE_W-1:0]    o_device_state,
    output logic [psc_pkg::CODE_W-1:0]    o_sub_state,
    output logic [psc_pkg::ERR_W-1:0]     o_error_code,
    output logic                          o_fault_reason,
    output logic                          o_op_result,
    output logic                          o_power_enable,
    output logic                          o_board_locked,
    output logic                          o_pulse_timer_run,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [psc_pkg::IDX_W-1:0]     i_cfg_index,
    input  logic [psc_pkg::CFG_W-1:0]     i_cfg_data
);
    import psc_pkg::*;

    t_cfg  w_cfg;
    t_res  w_res;
    t_req  r_req;
    t_res  r_res;
    logic  r_req_valid;
    logic  r_out_valid;
    logic  w_advance;

    assign o_cfg_ready = 1'b1;

    psc_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr_en (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_cfg   (w_cfg)
    );

    psc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_req_valid (w_advance),
        .i_req       (r_req),
        .o_res       (w_res)
    );

    assign w_advance  = r_req_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_req_valid && !w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_req_valid <= i_in_valid;
            end
            if (w_advance) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_req.op              <= i_op;
            r_req.battery_voltage <= i_battery_voltage;
            r_req.pulse_done      <= i_pulse_done;
        end
        if (w_advance) begin
            r_res <= w_res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_device_state    = r_res.device_state;
    assign o_sub_state       = r_res.sub_state;
    assign o_error_code      = r_res.error_code;
    assign o_fault_reason    = r_res.fault_reason;
    assign o_op_result       = r_res.op_result;
    assign o_power_enable    = r_res.power_enable;
    assign o_board_locked    = r_res.board_locked;
    assign o_pulse_timer_run = r_res.pulse_timer_run;

endmodule

// ===== verif/pulse_unit_state_controller_tb.sv =====
// Testbench of the pulse unit state controller: queued requests, shadow state machine, checks.
`timescale 1ns / 100ps

module pulse_unit_state_controller_tb;
    import psc_pkg::*;

    localparam int CLK_PERIOD = 12;
    localparam int PHASE_REQUESTS = 104;
    localparam logic [IDX_W-1:0] REG_UNMAPPED = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic in_valid = 1'b0;
    logic in_stall;
    t_req req_drv = '0;

    logic out_valid;
    logic out_stall = 1'b0;
    logic [CODE_W-1:0] dev_state_o;
    logic [CODE_W-1:0] sub_state_o;
    logic [ERR_W-1:0] error_code_o;
    logic fault_reason_o;
    logic op_result_o;
    logic power_enable_o;
    logic board_locked_o;
    logic pulse_timer_run_o;
    t_res seen_status;

    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    // shadow of the controller
    t_cfg cfg_shadow = '0;
    logic [CODE_W-1:0] ctl_state = DEV_NONE;
    logic [CODE_W-1:0] ctl_sub = SUBC_NONE;
    logic [63:0] now_ticks = '0;
    logic [63:0] charge_dl = '0;
    logic [63:0] cfg_dl = '0;
    logic [63:0] pause_dl = '0;
    logic fault_q = 1'b0;
    logic done_q = 1'b0;
    logic power_q = 1'b0;
    logic lock_q = 1'b1;
    logic timer_q = 1'b0;

    t_req pending_requests[$];
    t_res expected_status[$];
    t_res want_status;
    int queued_count = 0;
    int result_index = 0;
    int mismatch_count = 0;
    int send_gap_pct = 25;
    int recv_stall_pct = 46;

    always #(CLK_PERIOD / 2) clk = ~clk;

    pulse_unit_state_controller DUT (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .o_in_stall        (in_stall),
        .i_op              (req_drv.op),
        .i_battery_voltage (req_drv.battery_voltage),
        .i_pulse_done      (req_drv.pulse_done),
        .o_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .o_device_state    (dev_state_o),
        .o_sub_state       (sub_state_o),
        .o_error_code      (error_code_o),
        .o_fault_reason    (fault_reason_o),
        .o_op_result       (op_result_o),
        .o_power_enable    (power_enable_o),
        .o_board_locked    (board_locked_o),
        .o_pulse_timer_run (pulse_timer_run_o),
        .i_cfg_valid       (cfg_valid),
        .o_cfg_ready       (cfg_ready),
        .i_cfg_index       (cfg_index),
        .i_cfg_data        (cfg_data)
    );

    assign seen_status = {dev_state_o, sub_state_o, error_code_o, fault_reason_o, op_result_o,
                          power_enable_o, board_locked_o, pulse_timer_run_o};

    function automatic void set_mode(input logic [CODE_W-1:0] st, input logic [CODE_W-1:0] sub);
        ctl_state = st;
        ctl_sub = sub;
    endfunction

    function automatic void power_down();
        fault_q = 1'b0;
        done_q = 1'b0;
        lock_q = 1'b1;
        power_q = 1'b0;
        set_mode(DEV_NONE, SUBC_NONE);
    endfunction

    function automatic void halt_pulse();
        timer_q = 1'b0;
        lock_q = 1'b1;
        pause_dl = now_ticks + {48'd0, cfg_shadow.after_pulse_pause};
        charge_dl = now_ticks + {48'd0, cfg_shadow.recharge_timeout};
    endfunction

    function automatic void end_pulse();
        halt_pulse();
        set_mode(DEV_INPROC, SUBC_WAIT);
        done_q = 1'b1;
    endfunction

    function automatic void fire_pulse();
        set_mode(DEV_INPROC, SUBC_PULSE);
        lock_q = 1'b0;
        timer_q = 1'b1;
    endfunction

    function automatic void check_charge(input logic charged);
        if (charged) begin
            set_mode(DEV_READY, SUBC_NONE);
        end else if (now_ticks >= charge_dl) begin
            power_down();
            set_mode(DEV_FAULT, SUBC_NONE);
            fault_q = 1'b1;
        end
    endfunction

    function automatic t_res step_controller(input t_req rq);
        t_res r;
        logic [ERR_W-1:0] err;
        logic charged;
        err = ERR_OK;
        case (rq.op)
            OP_TICK: begin
                now_ticks = now_ticks + 64'd1;
                if (ctl_sub == SUBC_PULSE && rq.pulse_done)
                    end_pulse();
                charged = rq.battery_voltage >= cfg_shadow.battery_threshold;
                case (ctl_sub)
                    SUBC_POWERPREP: check_charge(charged);
                    SUBC_PULSEPREP: set_mode(DEV_CFGREADY, SUBC_NONE);
                    SUBC_WAIT: begin
                        if (now_ticks > pause_dl)
                            check_charge(charged);
                    end
                    default: begin
                        if (ctl_state == DEV_CFGREADY && now_ticks >= cfg_dl)
                            set_mode(DEV_READY, SUBC_NONE);
                    end
                endcase
            end
            OP_ENABLE: begin
                if (ctl_state == DEV_NONE) begin
                    charge_dl = now_ticks + {48'd0, cfg_shadow.full_charge_timeout};
                    set_mode(DEV_INPROC, SUBC_POWERPREP);
                    power_q = 1'b1;
                end else if (ctl_state != DEV_READY) begin
                    err = ERR_BLOCKED;
                end
            end
            OP_DISABLE: begin
                if (ctl_state == DEV_READY ||
                    (ctl_state == DEV_INPROC && ctl_sub == SUBC_POWERPREP))
                    power_down();
                else if (ctl_state != DEV_NONE)
                    err = ERR_BLOCKED;
            end
            OP_CONFIGURE: begin
                if (ctl_state == DEV_READY) begin
                    fault_q = 1'b0;
                    done_q = 1'b0;
                    cfg_dl = now_ticks + {48'd0, cfg_shadow.config_hold_timeout};
                    set_mode(DEV_INPROC, SUBC_PULSEPREP);
                end else begin
                    err = (ctl_state == DEV_INPROC) ? ERR_BLOCKED : ERR_NOTREADY;
                end
            end
            OP_SOFT_START: begin
                if (ctl_state == DEV_CFGREADY)
                    fire_pulse();
                else
                    err = (ctl_state == DEV_INPROC) ? ERR_BLOCKED : ERR_NOTREADY;
            end
            OP_STOP: begin
                if (ctl_state == DEV_INPROC) begin
                    halt_pulse();
                    set_mode(DEV_READY, SUBC_NONE);
                end
            end
            OP_CLEAR_FAULT: begin
                if (ctl_state == DEV_FAULT) begin
                    set_mode(DEV_NONE, SUBC_NONE);
                    fault_q = 1'b0;
                end
            end
            OP_EXT_START: begin
                if (ctl_state == DEV_CFGREADY)
                    fire_pulse();
            end
            OP_PULSE_DONE: begin
                if (ctl_sub == SUBC_PULSE)
                    end_pulse();
            end
            default: ;
        endcase
        r.device_state = ctl_state;
        r.sub_state = ctl_sub;
        r.error_code = err;
        r.fault_reason = fault_q;
        r.op_result = done_q;
        r.power_enable = power_q;
        r.board_locked = lock_q;
        r.pulse_timer_run = timer_q;
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input int unsigned got, input int unsigned want_v);
        if (got != want_v)
            report_mismatch($sformatf("result %0d %s: got %0d, expected %0d",
                                      result_index, name, got, want_v));
    endtask

    // request driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && !in_stall)
                expected_status.push_back(step_controller(req_drv));
            if (!in_valid || !in_stall) begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                    req_drv <= pending_requests.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                if (expected_status.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing pending",
                                              result_index));
                end else begin
                    want_status = expected_status.pop_front();
                    check_field("device_state", seen_status.device_state,
                                want_status.device_state);
                    check_field("sub_state", seen_status.sub_state, want_status.sub_state);
                    check_field("error_code", seen_status.error_code, want_status.error_code);
                    check_field("fault_reason", seen_status.fault_reason,
                                want_status.fault_reason);
                    check_field("op_result", seen_status.op_result, want_status.op_result);
                    check_field("power_enable", seen_status.power_enable,
                                want_status.power_enable);
                    check_field("board_locked", seen_status.board_locked,
                                want_status.board_locked);
                    check_field("pulse_timer_run", seen_status.pulse_timer_run,
                                want_status.pulse_timer_run);
                end
                result_index++;
            end
            out_stall <= ($urandom_range(99) < recv_stall_pct);
        end
    end

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_FULL_CHARGE: cfg_shadow.full_charge_timeout = val;
            REG_RECHARGE:    cfg_shadow.recharge_timeout = val;
            REG_CFG_HOLD:    cfg_shadow.config_hold_timeout = val;
            REG_PAUSE:       cfg_shadow.after_pulse_pause = val;
            REG_THRESHOLD:   cfg_shadow.battery_threshold = val;
            default: ;
        endcase
    endtask

    task automatic load_settings(input logic [CFG_W-1:0] full_v, input logic [CFG_W-1:0] rech_v,
                                 input logic [CFG_W-1:0] hold_v, input logic [CFG_W-1:0] pause_v,
                                 input logic [CFG_W-1:0] thr_v);
        write_reg(REG_FULL_CHARGE, full_v);
        write_reg(REG_RECHARGE, rech_v);
        write_reg(REG_CFG_HOLD, hold_v);
        write_reg(REG_PAUSE, pause_v);
        write_reg(REG_THRESHOLD, thr_v);
    endtask

    task automatic wait_drained();
        do @(negedge clk);
        while (pending_requests.size() != 0 || in_valid || expected_status.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic push_request(input logic [OP_W-1:0] op, input logic [VOLT_W-1:0] volts,
                                input logic done);
        t_req rq;
        rq.op = op;
        rq.battery_voltage = volts;
        rq.pulse_done = done;
        pending_requests.push_back(rq);
        queued_count++;
    endtask

    function automatic logic [VOLT_W-1:0] pick_volts(input logic want_charged);
        logic [VOLT_W-1:0] thr;
        thr = cfg_shadow.battery_threshold;
        if (want_charged || thr == 0) begin
            case ($urandom_range(2))
                0: return thr;
                1: return 16'hFFFF;
                default: return thr + $urandom_range(16'hFFFF - thr);
            endcase
        end
        case ($urandom_range(2))
            0: return thr - 16'd1;
            1: return '0;
            default: return $urandom_range(thr - 1);
        endcase
    endfunction

    task automatic push_tick(input logic want_charged, input logic done);
        push_request(OP_TICK, pick_volts(want_charged), done);
    endtask

    task automatic push_command(input logic [OP_W-1:0] op);
        push_request(op, $urandom, $urandom_range(1));
    endtask

    // charge, configure, fire, finish and pause, with random detours
    task automatic push_pulse_cycle();
        if ($urandom_range(3) == 0)
            push_command(OP_CLEAR_FAULT);
        if ($urandom_range(4) != 0)
            push_command(OP_ENABLE);
        repeat ($urandom_range(1, 3)) push_tick($urandom_range(3) != 0, $urandom_range(1));
        push_command(OP_CONFIGURE);
        push_tick($urandom_range(1), $urandom_range(1));
        repeat ($urandom_range(2)) push_tick($urandom_range(1), $urandom_range(1));
        push_command($urandom_range(1) ? OP_SOFT_START : OP_EXT_START);
        repeat ($urandom_range(2)) push_tick($urandom_range(1), $urandom_range(4) == 0);
        case ($urandom_range(3))
            0: push_command(OP_PULSE_DONE);
            1: push_tick($urandom_range(1), 1'b1);
            2: push_command(OP_STOP);
            default: ;
        endcase
        repeat ($urandom_range(1, 5)) push_tick($urandom_range(4) != 0, $urandom_range(1));
        if ($urandom_range(5) == 0)
            push_command(OP_STOP);
        if ($urandom_range(7) == 0)
            push_command(OP_DISABLE);
    endtask

    initial begin
        int phase;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        load_settings(16'd2, 16'd3, 16'd2, 16'd1, 16'd1000);
        push_request(OP_TICK, 16'h0000, 1'b1);
        push_request(4'hF, 16'hFFFF, 1'b1);
        push_request(OP_SOFT_START, 16'h0000, 1'b0);
        push_request(OP_CONFIGURE, 16'hFFFF, 1'b0);
        push_request(OP_DISABLE, 16'h0000, 1'b1);
        push_request(OP_STOP, 16'h5A5A, 1'b0);
        push_request(OP_CLEAR_FAULT, 16'hA5A5, 1'b1);
        push_request(OP_PULSE_DONE, 16'h0000, 1'b1);
        push_request(OP_ENABLE, 16'h0000, 1'b0);
        push_request(OP_CONFIGURE, 16'h0000, 1'b0);
        push_request(OP_SOFT_START, 16'h0000, 1'b0);
        push_request(OP_TICK, 16'd999, 1'b0);
        push_request(OP_TICK, 16'd1000, 1'b0);
        push_request(OP_CONFIGURE, 16'h0000, 1'b0);
        push_request(OP_TICK, 16'h0000, 1'b0);
        push_request(OP_SOFT_START, 16'h0000, 1'b0);
        push_request(OP_CLEAR_WARN, 16'hFFFF, 1'b1);
        push_request(OP_PULSE_DONE, 16'h0000, 1'b0);
        push_request(OP_STOP, 16'h0000, 1'b0);
        push_request(OP_DISABLE, 16'h0000, 1'b0);
        push_request(OP_ENABLE, 16'h0000, 1'b0);
        push_request(OP_TICK, 16'h0000, 1'b0);
        push_request(OP_TICK, 16'h0000, 1'b0);
        push_request(OP_DISABLE, 16'h0000, 1'b0);
        push_request(OP_CLEAR_FAULT, 16'h0000, 1'b0);
        wait_drained();

        for (phase = 0; phase < 6; phase++) begin
            case (phase / 2)
                0: begin
                    send_gap_pct = 25;
                    recv_stall_pct = 46;
                end
                1: begin
                    send_gap_pct = 46;
                    recv_stall_pct = 25;
                end
                default: begin
                    send_gap_pct = 0;
                    recv_stall_pct = 0;
                end
            endcase
            case (phase)
                0: load_settings(16'd5, 16'd2, 16'd3, 16'd2, $urandom_range(1, 60000));
                1: begin
                    load_settings('0, '0, '0, '0, '0);
                    write_reg(REG_UNMAPPED, 16'hFFFF);
                end
                2: load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
                3: load_settings(16'd1, '0, 16'd1, '0, 16'd40000);
                4: load_settings($urandom_range(6), $urandom_range(6), $urandom_range(6),
                                 $urandom_range(6), $urandom);
                default: load_settings(16'd3, 16'd4, '0, 16'd3, 16'h8000);
            endcase
            queued_count = 0;
            while (queued_count < PHASE_REQUESTS) begin
                if ($urandom_range(4) == 0)
                    push_request($urandom_range(15), $urandom, $urandom_range(1));
                else
                    push_pulse_cycle();
            end
            wait_drained();
        end

        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
hdl/psc_pkg.sv
hdl/psc_cfg_regs.sv
hdl/psc_core.sv
hdl/pulse_unit_state_controller.sv
verif/pulse_unit_state_controller_tb.sv
